// ===== sv/line_follow_pid_speed_controller_unit_defines.svh =====
// assertion macros for the line follower speed controller
`ifndef LINE_FOLLOW_PID_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`define LINE_FOLLOW_PID_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LFPID_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define LFPID_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LFPID_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define LFPID_ASSERT_NXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/lfpid_pkg.sv =====
// types and constants shared by the line follower speed controller
package lfpid_pkg;

    localparam int CELL_COUNT  = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int ALPHA_W     = 16;
    localparam int FILT_W      = SAMPLE_BITS + FRAC_BITS;
    localparam int IDX_W       = $clog2(CELL_COUNT);
    localparam int WEIGHT_STEP = 1000;
    localparam int WT_W        = $clog2((CELL_COUNT - 1) * WEIGHT_STEP + 1);
    localparam int NUM_W       = SAMPLE_BITS + WT_W + $clog2(CELL_COUNT);
    localparam int DEN_W       = SAMPLE_BITS + $clog2(CELL_COUNT) + 1;
    localparam int DIV_W       = 41;
    localparam int POS_W       = 13;
    localparam int PWM_W       = 14;
    localparam int LR_W        = 27;
    localparam int LIM_W       = 23;

    localparam logic [ALPHA_W-1:0] RANGE_ALPHA = 16'd655;
    localparam logic [POS_W-1:0]   CENTRE      = 13'd3500;
    localparam logic [POS_W-1:0]   POS_MAX     = 13'd7000;
    localparam int                 BASE_DRIVE  = 3000;
    localparam logic [11:0]        NEAR_LIMIT  = 12'd600;
    localparam logic [3:0]         BLINK_LAST  = 4'd9;
    localparam logic [6:0]         HALT_AFTER  = 7'd100;
    // ceil(2^22 / 5), exact division by 5 for values below 2^22
    localparam logic [19:0]        RECIP_5     = 20'd838861;

    typedef enum logic [2:0] {
        CFG_WANTED_DISTANCE = 3'd0,
        CFG_MAX_PWM         = 3'd1,
        CFG_MIN_PWM         = 3'd2,
        CFG_DISTANCE_GAIN   = 3'd3,
        CFG_GAIN_P          = 3'd4,
        CFG_GAIN_I          = 3'd5,
        CFG_GAIN_D          = 3'd6,
        CFG_SENSOR_ALPHA    = 3'd7
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE, S_MERGE, S_POS_DIV, S_POS_WAIT, S_LIMIT_MUL, S_LIMIT,
        S_SUM, S_SUM_WAIT, S_P_MUL, S_I_MUL, S_D_MUL, S_MIX, S_AVG,
        S_L_MUL, S_L_DIV, S_L_WAIT, S_R_MUL, S_R_DIV, S_R_WAIT,
        S_FINISH, S_HALT_OUT
    } t_state;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] cell_0;
        logic [SAMPLE_BITS-1:0] cell_1;
        logic [SAMPLE_BITS-1:0] cell_2;
        logic [SAMPLE_BITS-1:0] cell_3;
        logic [SAMPLE_BITS-1:0] cell_4;
        logic [SAMPLE_BITS-1:0] cell_5;
        logic [SAMPLE_BITS-1:0] cell_6;
        logic [SAMPLE_BITS-1:0] cell_7;
        logic [SAMPLE_BITS-1:0] range_sample;
    } t_in_item;

    typedef struct packed {
        logic [PWM_W-1:0] left_pwm;
        logic [PWM_W-1:0] right_pwm;
        logic [POS_W-1:0] line_position;
        logic             led_on;
        logic             halted;
    } t_out_item;

    function automatic logic [WT_W-1:0] cell_weight(input logic [IDX_W-1:0] idx);
        cell_weight = WT_W'(idx * WEIGHT_STEP);
    endfunction

endpackage

// ===== sv/lfpid_lane.sv =====
// one first-order low-pass filter lane with kept state
module lfpid_lane
    import lfpid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [ALPHA_W-1:0]     i_alpha,
    output logic [FILT_W-1:0]      o_state
);

    logic [FILT_W-1:0]          r_state;
    logic [FILT_W-1:0]          n_state;
    logic [FILT_W-1:0]          ax;
    logic [ALPHA_W:0]           beta;
    logic [ALPHA_W+FILT_W:0]    bf;

    always_comb begin
        ax      = FILT_W'(i_alpha) * FILT_W'(i_sample);
        beta    = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, i_alpha};
        bf      = beta * r_state;
        n_state = ax + bf[ALPHA_W+FILT_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== sv/lfpid_div.sv =====
// shared radix-2 restoring divider, one quotient bit per cycle
module lfpid_div
    import lfpid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== sv/line_follow_pid_speed_controller_unit.sv =====
// Line follower drive controller: one accepted item is one control tick. Eight filter
// lanes update every photo-cell state and a ninth the distance state in the accept cycle,
// a merge pass then adds the weighted cells one per cycle, and a single shared 41-bit
// divider, one quotient bit per cycle, forms the line position and the two rescaled motor
// commands; the integral term is divided by 20 through a reciprocal multiply. A tick runs the
// merge, the position division, the limit and integral steps, the three gain multiplies, the
// mix and average steps, the left and right divisions and the output step; with all cells
// dark the position division is skipped, and a tick after the block has halted goes straight
// to the output step. The next item is taken once the current result sits in the output
// register, so a stalled consumer holds at most one result.
`include "line_follow_pid_speed_controller_unit_defines.svh"
module line_follow_pid_speed_controller_unit
    import lfpid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    // configuration
    logic [11:0]        r_wanted;
    logic [PWM_W-1:0]   r_max_pwm;
    logic [PWM_W-1:0]   r_min_pwm;
    logic [7:0]         r_dgain;
    logic [7:0]         r_gain_p;
    logic [7:0]         r_gain_i;
    logic [7:0]         r_gain_d;
    logic [ALPHA_W-1:0] r_alpha;

    // control state
    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [POS_W-1:0]   r_held;
    logic [PWM_W-1:0]   r_speed_limit;
    logic [6:0]         r_ticks;
    logic [3:0]         r_blink;
    logic               r_led;
    logic               r_stopped;
    logic signed [20:0] r_sum;
    logic signed [12:0] r_last_err;
    logic               r_out_valid;

    // datapath
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [POS_W-1:0]         r_pos;
    logic signed [LIM_W-1:0]  r_lim_prod;
    logic [PWM_W-1:0]         r_limit;
    logic signed [13:0]       r_err;
    logic signed [16:0]       r_sumq;
    logic signed [22:0]       r_pp;
    logic signed [25:0]       r_pi;
    logic signed [28:0]       r_pd;
    logic [LR_W-1:0]          r_left;
    logic [LR_W-1:0]          r_right;
    logic [LR_W-1:0]          r_avg;
    logic [DIV_W-1:0]         r_prod;
    logic [16:0]              r_lres;
    logic [16:0]              r_rres;
    t_out_item                r_out;

    logic                     in_xfer;
    logic                     out_free;
    logic                     lane_en;
    logic [SAMPLE_BITS-1:0]   samples [CELL_COUNT];
    logic [FILT_W-1:0]        cell_state [CELL_COUNT];
    logic [FILT_W-1:0]        range_state;
    logic [SAMPLE_BITS-1:0]   cell_int;
    logic [SAMPLE_BITS-1:0]   range_int;

    logic                     div_start;
    logic [DIV_W-1:0]         div_num;
    logic [DIV_W-1:0]         div_den;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;

    logic signed [LIM_W:0]    lim;
    logic                     lim_low;
    logic [6:0]               ticks_inc;
    logic                     halt_now;
    logic signed [21:0]       sum_ext;
    logic signed [20:0]       sum_sat;
    logic signed [13:0]       err;
    logic [21:0]              sum_mag;
    logic [41:0]              sum_prod;
    logic [16:0]              sum_quo;
    logic signed [14:0]       derr;
    logic signed [23:0]       gd_prod;
    logic signed [29:0]       pid;
    logic signed [30:0]       left_s;
    logic signed [30:0]       right_s;
    logic [16:0]              fin_left;
    logic [16:0]              fin_right;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign lane_en  = in_xfer && !r_stopped;

    assign samples[0] = i_in_data.cell_0;
    assign samples[1] = i_in_data.cell_1;
    assign samples[2] = i_in_data.cell_2;
    assign samples[3] = i_in_data.cell_3;
    assign samples[4] = i_in_data.cell_4;
    assign samples[5] = i_in_data.cell_5;
    assign samples[6] = i_in_data.cell_6;
    assign samples[7] = i_in_data.cell_7;

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_lane
        lfpid_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (lane_en),
            .i_sample (samples[g]),
            .i_alpha  (r_alpha),
            .o_state  (cell_state[g])
        );
    end

    lfpid_lane u_range_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (lane_en),
        .i_sample (i_in_data.range_sample),
        .i_alpha  (RANGE_ALPHA),
        .o_state  (range_state)
    );

    lfpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign cell_int  = cell_state[r_idx][FILT_W-1:FRAC_BITS];
    assign range_int = range_state[FILT_W-1:FRAC_BITS];

    // speed limit, standstill, integral, derivative, mix and output clamp terms
    always_comb begin
        lim = $signed({{(LIM_W+1-PWM_W){1'b0}}, r_speed_limit});
        if (range_int < NEAR_LIMIT) begin
            lim = $signed({{(LIM_W+1-PWM_W){1'b0}}, r_max_pwm});
        end
        if (range_int > NEAR_LIMIT) begin
            lim = (LIM_W+1)'(r_lim_prod);
        end
        if (lim > $signed({{(LIM_W+1-PWM_W){1'b0}}, r_max_pwm})) begin
            lim = $signed({{(LIM_W+1-PWM_W){1'b0}}, r_max_pwm});
        end
        lim_low   = (lim <= $signed({{(LIM_W+1-PWM_W){1'b0}}, r_min_pwm}));
        ticks_inc = r_ticks + 1'b1;
        halt_now  = lim_low && (ticks_inc == HALT_AFTER);
        err       = $signed({1'b0, CENTRE}) - $signed({1'b0, r_pos});
        sum_ext   = 22'(r_sum) + 22'(err);
        if (sum_ext > 22'sd1048575) begin
            sum_sat = 21'sd1048575;
        end else if (sum_ext < -22'sd1048576) begin
            sum_sat = 21'sh100000;
        end else begin
            sum_sat = sum_ext[20:0];
        end
        sum_mag   = (r_sum < 0) ? 22'(-22'(r_sum)) : 22'(r_sum);
        // divide by 20 as a divide by 4 then a reciprocal divide by 5
        sum_prod  = {22'b0, sum_mag[21:2]} * {22'b0, RECIP_5};
        sum_quo   = sum_prod[38:22];
        derr      = 15'(r_err) - 15'(r_last_err);
        gd_prod   = $signed({1'b0, r_gain_d}) * derr;
        pid       = 30'(r_pp) + 30'(r_pi) + 30'(r_pd);
        left_s    = 31'sd3000 - 31'(pid);
        right_s   = 31'(BASE_DRIVE) + 31'(pid);
        fin_left  = r_lres;
        fin_right = r_rres;
        if (fin_left < {3'b0, r_min_pwm} && fin_right > {3'b0, r_min_pwm}) begin
            fin_left = {3'b0, r_min_pwm};
        end
        if (fin_left > {3'b0, r_min_pwm} && fin_right < {3'b0, r_min_pwm}) begin
            fin_right = {3'b0, r_min_pwm};
        end
        if (fin_left > {3'b0, r_max_pwm}) begin
            fin_left = {3'b0, r_max_pwm};
        end
        if (fin_right > {3'b0, r_max_pwm}) begin
            fin_right = {3'b0, r_max_pwm};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = r_stopped ? S_HALT_OUT : S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_idx == IDX_W'(CELL_COUNT - 1)) begin
                    n_state = S_POS_DIV;
                end
            end
            S_POS_DIV:   n_state = (r_den == '0) ? S_LIMIT_MUL : S_POS_WAIT;
            S_POS_WAIT:  n_state = div_done ? S_LIMIT_MUL : S_POS_WAIT;
            S_LIMIT_MUL: n_state = S_LIMIT;
            S_LIMIT:     n_state = halt_now ? S_HALT_OUT : S_SUM;
            S_SUM:       n_state = S_SUM_WAIT;
            S_SUM_WAIT:  n_state = S_P_MUL;
            S_P_MUL:     n_state = S_I_MUL;
            S_I_MUL:     n_state = S_D_MUL;
            S_D_MUL:     n_state = S_MIX;
            S_MIX:       n_state = S_AVG;
            S_AVG:       n_state = S_L_MUL;
            S_L_MUL:     n_state = (r_avg == '0) ? S_FINISH : S_L_DIV;
            S_L_DIV:     n_state = S_L_WAIT;
            S_L_WAIT:    n_state = div_done ? S_R_MUL : S_L_WAIT;
            S_R_MUL:     n_state = S_R_DIV;
            S_R_DIV:     n_state = S_R_WAIT;
            S_R_WAIT:    n_state = div_done ? S_FINISH : S_R_WAIT;
            S_FINISH:    n_state = out_free ? S_IDLE : S_FINISH;
            S_HALT_OUT:  n_state = out_free ? S_IDLE : S_HALT_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    // divider feed
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_POS_DIV: begin
                div_start = (r_den != '0);
                div_num   = DIV_W'(r_num);
                div_den   = DIV_W'(r_den);
            end
            S_L_DIV, S_R_DIV: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = DIV_W'(r_avg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted  <= 12'd1100;
            r_max_pwm <= 14'd6000;
            r_min_pwm <= 14'd3000;
            r_dgain   <= 8'd14;
            r_gain_p  <= 8'd2;
            r_gain_i  <= 8'd1;
            r_gain_d  <= 8'd2;
            r_alpha   <= 16'd1638;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WANTED_DISTANCE: r_wanted  <= i_cfg_data[11:0];
                CFG_MAX_PWM:         r_max_pwm <= i_cfg_data[PWM_W-1:0];
                CFG_MIN_PWM:         r_min_pwm <= i_cfg_data[PWM_W-1:0];
                CFG_DISTANCE_GAIN:   r_dgain   <= i_cfg_data[7:0];
                CFG_GAIN_P:          r_gain_p  <= i_cfg_data[7:0];
                CFG_GAIN_I:          r_gain_i  <= i_cfg_data[7:0];
                CFG_GAIN_D:          r_gain_d  <= i_cfg_data[7:0];
                CFG_SENSOR_ALPHA:    r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_held        <= CENTRE;
            r_speed_limit <= '0;
            r_ticks       <= '0;
            r_blink       <= '0;
            r_led         <= 1'b0;
            r_stopped     <= 1'b0;
            r_sum         <= '0;
            r_last_err    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (r_state == S_MERGE) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_POS_WAIT && div_done) begin
                r_held <= (div_quo > DIV_W'(POS_MAX)) ? POS_MAX : div_quo[POS_W-1:0];
            end
            if (r_state == S_LIMIT) begin
                if (lim_low) begin
                    r_speed_limit <= '0;
                    r_ticks       <= ticks_inc;
                    r_blink       <= (r_blink == BLINK_LAST) ? 4'd0 : r_blink + 1'b1;
                    if (r_blink == BLINK_LAST) begin
                        r_led <= ~r_led;
                    end
                    if (halt_now) begin
                        r_stopped <= 1'b1;
                    end
                end else begin
                    r_speed_limit <= lim[PWM_W-1:0];
                    if (r_ticks != '0) begin
                        r_ticks <= '0;
                        r_blink <= '0;
                        r_led   <= 1'b1;
                    end
                end
                if (!halt_now) begin
                    r_sum <= sum_sat;
                end
            end
            if (r_state == S_MIX) begin
                r_last_err <= r_err[12:0];
            end
            if ((r_state == S_FINISH || r_state == S_HALT_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_num <= '0;
                r_den <= '0;
                r_pos <= r_held;
            end
            S_MERGE: begin
                r_num <= r_num + NUM_W'(cell_int) * NUM_W'(cell_weight(r_idx));
                r_den <= r_den + DEN_W'(cell_int);
            end
            S_POS_WAIT: begin
                if (div_done) begin
                    r_pos <= (div_quo > DIV_W'(POS_MAX)) ? POS_MAX : div_quo[POS_W-1:0];
                end
            end
            S_LIMIT_MUL: begin
                r_lim_prod <= $signed({1'b0, r_dgain})
                    * ($signed({2'b0, r_wanted}) - $signed({2'b0, range_int}));
            end
            S_LIMIT: begin
                r_limit <= lim_low ? '0 : lim[PWM_W-1:0];
                r_err   <= err;
            end
            S_SUM: begin
                r_sumq <= $signed(sum_quo);
            end
            S_SUM_WAIT: begin
                if (r_sum < 0) begin
                    r_sumq <= -r_sumq;
                end
            end
            S_P_MUL: r_pp <= $signed({1'b0, r_gain_p}) * r_err;
            S_I_MUL: r_pi <= $signed({1'b0, r_gain_i}) * r_sumq;
            S_D_MUL: r_pd <= (29'(gd_prod) <<< 4) + (29'(gd_prod) <<< 2);
            S_MIX: begin
                r_left  <= (left_s < 0) ? '0 : left_s[LR_W-1:0];
                r_right <= (right_s < 0) ? '0 : right_s[LR_W-1:0];
            end
            S_AVG: begin
                r_avg <= LR_W'(({1'b0, r_left} + {1'b0, r_right}) >> 1);
            end
            S_L_MUL: begin
                r_prod <= DIV_W'(r_left) * DIV_W'(r_limit);
                if (r_avg == '0) begin
                    r_lres <= '0;
                    r_rres <= '0;
                end
            end
            S_L_WAIT: begin
                if (div_done) begin
                    r_lres <= div_quo[16:0];
                end
            end
            S_R_MUL: r_prod <= DIV_W'(r_right) * DIV_W'(r_limit);
            S_R_WAIT: begin
                if (div_done) begin
                    r_rres <= div_quo[16:0];
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out.left_pwm      <= fin_left[PWM_W-1:0];
                    r_out.right_pwm     <= fin_right[PWM_W-1:0];
                    r_out.line_position <= r_pos;
                    r_out.led_on        <= r_led;
                    r_out.halted        <= 1'b0;
                end
            end
            S_HALT_OUT: begin
                if (out_free) begin
                    r_out.left_pwm      <= '0;
                    r_out.right_pwm     <= '0;
                    r_out.line_position <= r_pos;
                    r_out.led_on        <= r_led;
                    r_out.halted        <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LFPID_ASSERT_IMP(a_halt_no_drive, i_clk, i_rst_n, o_out_valid && o_out_data.halted, o_out_data.left_pwm == '0 && o_out_data.right_pwm == '0, "halted result with drive")
    `LFPID_ASSERT_IMP(a_stop_count, i_clk, i_rst_n, r_stopped, r_ticks == HALT_AFTER, "halted before standstill count")
    `LFPID_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_done, r_state == S_POS_WAIT || r_state == S_L_WAIT || r_state == S_R_WAIT, "divider result with no waiting step")
    `LFPID_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_xfer, r_state != S_IDLE, "transfer left the sequencer idle")

endmodule

// ===== bench/line_follow_pid_speed_controller_unit_test.sv =====
// self-checking testbench for the line follower pid speed controller
`timescale 1ns / 100ps
module line_follow_pid_speed_controller_unit_test;
    import lfpid_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;

    line_follow_pid_speed_controller_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // controller copy
    longint unsigned r_wanted, r_max, r_min, r_dgain, r_kp, r_ki, r_kd, r_alpha;
    longint unsigned cell_lp [CELL_COUNT];
    longint unsigned range_lp;
    longint lim_q, err_acc, prev_err, hold_pos;
    int unsigned still_cnt, led_q, halt_q;

    t_out_item pwm_expected [$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint unsigned lowpass(longint unsigned f, longint unsigned x,
                                                longint unsigned a);
        return (a * (x << FRAC_BITS) + (64'd65536 - a) * f) >> FRAC_BITS;
    endfunction

    task automatic reset_controller();
        r_wanted = 1100; r_max = 6000; r_min = 3000; r_dgain = 14;
        r_kp = 2; r_ki = 1; r_kd = 2; r_alpha = 1638;
        foreach (cell_lp[i]) cell_lp[i] = 0;
        range_lp = 0; lim_q = 0; err_acc = 0; prev_err = 0;
        hold_pos = 3500; still_cnt = 0; led_q = 0; halt_q = 0;
    endtask

    function automatic t_out_item predict_drive(t_in_item it);
        t_out_item r;
        longint unsigned smp [CELL_COUNT + 1];
        longint unsigned num, den, v;
        longint pos, range_int, limit, err, pid, left, right, avg;
        num = 0; den = 0;
        smp = '{it.cell_0, it.cell_1, it.cell_2, it.cell_3, it.cell_4, it.cell_5,
                it.cell_6, it.cell_7, it.range_sample};
        if (halt_q) begin
            r = '0;
            r.line_position = hold_pos[POS_W-1:0];
            r.led_on = led_q[0];
            r.halted = 1'b1;
            return r;
        end
        for (int i = 0; i < CELL_COUNT; i++) begin
            cell_lp[i] = lowpass(cell_lp[i], smp[i], r_alpha);
            v = cell_lp[i] >> FRAC_BITS;
            num += v * i * 1000;
            den += v;
        end
        range_lp = lowpass(range_lp, smp[CELL_COUNT], 655);
        if (den != 0) begin
            pos = (num / den > 7000) ? 7000 : longint'(num / den);
            hold_pos = pos;
        end else begin
            pos = hold_pos;
        end
        range_int = longint'(range_lp >> FRAC_BITS);
        limit = lim_q;
        if (range_int < 600) limit = r_max;
        if (range_int > 600) limit = longint'(r_dgain) * (longint'(r_wanted) - range_int);
        if (limit > longint'(r_max)) limit = r_max;
        if (limit <= longint'(r_min)) begin
            limit = 0;
            still_cnt++;
            if (still_cnt % 10 == 0) led_q ^= 1;
            if (still_cnt >= 100) begin
                lim_q = 0;
                halt_q = 1;
                r = '0;
                r.line_position = pos[POS_W-1:0];
                r.led_on = led_q[0];
                r.halted = 1'b1;
                return r;
            end
        end
        if (limit > longint'(r_min) && still_cnt != 0) begin
            still_cnt = 0;
            led_q = 1;
        end
        lim_q = limit;
        err = 3500 - pos;
        err_acc += err;
        if (err_acc > 1048575) err_acc = 1048575;
        if (err_acc < -1048576) err_acc = -1048576;
        pid = longint'(r_kp) * err + longint'(r_ki) * (err_acc / 20)
            + longint'(r_kd) * ((err - prev_err) * 20);
        prev_err = err;
        left = 3000 - pid;
        right = 3000 + pid;
        if (left < 0) left = 0;
        if (right < 0) right = 0;
        avg = (left + right) / 2;
        if (avg != 0) begin
            left = left * limit / avg;
            right = right * limit / avg;
        end else begin
            left = 0;
            right = 0;
        end
        if (left < longint'(r_min) && right > longint'(r_min)) left = r_min;
        if (left > longint'(r_min) && right < longint'(r_min)) right = r_min;
        if (left > longint'(r_max)) left = r_max;
        if (right > longint'(r_max)) right = r_max;
        r.left_pwm = left[PWM_W-1:0];
        r.right_pwm = right[PWM_W-1:0];
        r.line_position = pos[POS_W-1:0];
        r.led_on = led_q[0];
        r.halted = 1'b0;
        return r;
    endfunction

    task automatic write_reg(t_cfg_index idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[15:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_WANTED_DISTANCE: r_wanted = value & 12'hfff;
            CFG_MAX_PWM:         r_max = value & 14'h3fff;
            CFG_MIN_PWM:         r_min = value & 14'h3fff;
            CFG_DISTANCE_GAIN:   r_dgain = value & 8'hff;
            CFG_GAIN_P:          r_kp = value & 8'hff;
            CFG_GAIN_I:          r_ki = value & 8'hff;
            CFG_GAIN_D:          r_kd = value & 8'hff;
            default:             r_alpha = value & 16'hffff;
        endcase
    endtask

    task automatic wait_drained();
        while (pwm_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // one transfer on the input channel, called at a falling edge
    task automatic send_tick(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pwm_expected.push_back(predict_drive(it));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_in_item random_tick(int unsigned rlo, int unsigned rhi);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(3) != 0) it.range_sample = 12'($urandom_range(rhi, rlo));
        return it;
    endfunction

    function automatic t_in_item flat_tick(logic [11:0] c, logic [11:0] r);
        return '{c, c, c, c, c, c, c, c, r};
    endfunction

    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (pwm_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected transfer %p", o_out_data);
                end else begin
                    want = pwm_expected.pop_front();
                    if (o_out_data.left_pwm !== want.left_pwm
                        || o_out_data.right_pwm !== want.right_pwm
                        || o_out_data.line_position !== want.line_position
                        || o_out_data.led_on !== want.led_on
                        || o_out_data.halted !== want.halted) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, o_out_data);
                    end
                end
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic test_extremes();
        send_tick(flat_tick(12'd0, 12'd0));
        send_tick(flat_tick(12'hfff, 12'hfff));
        send_tick('{12'hfff, '0, '0, '0, '0, '0, '0, '0, 12'd0});
        send_tick('{'0, '0, '0, '0, '0, '0, '0, 12'hfff, 12'd0});
        send_tick('{12'h555, 12'haaa, 12'h555, 12'haaa, 12'h555, 12'haaa, 12'h555,
                    12'haaa, 12'haaa});
        wait_drained();
    endtask

    task automatic test_gains();
        write_reg(CFG_SENSOR_ALPHA, 16'hffff);
        write_reg(CFG_GAIN_P, 255);
        write_reg(CFG_GAIN_I, 255);
        write_reg(CFG_GAIN_D, 255);
        write_reg(CFG_MAX_PWM, 12000);
        write_reg(CFG_MIN_PWM, 0);
        for (int i = 0; i < 10; i++) send_tick(random_tick(0, 599));
        send_tick(flat_tick(12'd0, 12'd0));
        wait_drained();
        write_reg(CFG_SENSOR_ALPHA, 0);
        write_reg(CFG_GAIN_P, 0);
        write_reg(CFG_GAIN_I, 0);
        write_reg(CFG_GAIN_D, 0);
        for (int i = 0; i < 4; i++) send_tick(random_tick(0, 599));
        wait_drained();
    endtask

    task automatic test_random_run(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(CFG_SENSOR_ALPHA, $urandom_range(65535));
        write_reg(CFG_GAIN_P, $urandom_range(255));
        write_reg(CFG_GAIN_I, $urandom_range(255));
        write_reg(CFG_GAIN_D, $urandom_range(255));
        write_reg(CFG_DISTANCE_GAIN, $urandom_range(255));
        write_reg(CFG_WANTED_DISTANCE, $urandom_range(4095));
        write_reg(CFG_MAX_PWM, $urandom_range(12000));
        write_reg(CFG_MIN_PWM, $urandom_range(6000));
        for (int i = 0; i < n; i++) send_tick(random_tick(0, 1500));
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_tick(random_tick(0, 599));
        join
        wait_drained();
    endtask

    // distance rule and standstill: blink, recover, halt for good
    task automatic test_standstill();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_SENSOR_ALPHA, 16'hffff);
        write_reg(CFG_MAX_PWM, 6000);
        write_reg(CFG_MIN_PWM, 3000);
        write_reg(CFG_DISTANCE_GAIN, 14);
        write_reg(CFG_WANTED_DISTANCE, 1100);
        write_reg(CFG_GAIN_P, 2);
        write_reg(CFG_GAIN_I, 1);
        write_reg(CFG_GAIN_D, 2);
        for (int i = 0; i < 25; i++) send_tick(flat_tick(12'($urandom), 12'd4095));
        for (int i = 0; i < 40; i++) send_tick(flat_tick(12'($urandom), 12'd0));
        for (int i = 0; i < 130; i++) send_tick(random_tick(3000, 4095));
        wait_drained();
    endtask

    initial begin
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WANTED_DISTANCE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        reset_controller();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_gains();
        test_random_run(70, 0, 0);
        test_random_run(70, 59, 0);
        test_random_run(70, 0, 59);
        test_random_run(70, 17, 17);
        test_backpressure();
        test_standstill();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/lfpid_pkg.sv
sv/lfpid_lane.sv
sv/lfpid_div.sv
sv/line_follow_pid_speed_controller_unit.sv
bench/line_follow_pid_speed_controller_unit_test.sv
